FILE: hdl/fifo_queue_with_cancel_by_key_core_assert.svh
// assertion macros for the order queue checker
`ifndef FIFO_QUEUE_WITH_CANCEL_BY_KEY_CORE_ASSERT_SVH
`define FIFO_QUEUE_WITH_CANCEL_BY_KEY_CORE_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define FQCBK_CHECK_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fqcbk check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define FQCBK_CHECK_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fqcbk check failed");

`endif

FILE: hdl/fqcbk_pkg.sv
// shared constants and codes for the order queue
`default_nettype none

package fqcbk_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int KEY_BITS_DEF  = 32;
    localparam int FOOD_BITS_DEF = 16;

    localparam int MODE_W  = 3;
    localparam int KEY_W   = 32;
    localparam int FOOD_W  = 16;
    localparam int ID_W    = 16;
    localparam int COUNT_W = 5;
    localparam int CODE_W  = 2;

    localparam logic [ID_W-1:0] ID_START = 16'd1001;

    localparam logic [MODE_W-1:0] MODE_ENQ    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SERVE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CANCEL = 3'd5;

    localparam logic [CODE_W-1:0] RES_OK   = 2'd0;
    localparam logic [CODE_W-1:0] RES_MISS = 2'd1;
    localparam logic [CODE_W-1:0] RES_FULL = 2'd2;

endpackage

`default_nettype wire

FILE: hdl/fifo_queue_with_cancel_by_key_core.sv
// order queue top level: fifo with search and cancel by customer key
`default_nettype none

// Order queue with search and cancel by key. A command is taken when start is high and
// busy is low; each result beat shows on the o_ ports for one cycle under o_valid and
// cannot be held off, and o_last marks the final beat of a command. Entries live in a
// single memory with one read and one write port, so the steps that touch entries run
// one after another: serve and cancel move the younger entries down one per cycle, and
// search gives matches oldest first, each once the scan finds the next match or
// reaches the end. No clearing pass after reset.
module fifo_queue_with_cancel_by_key_core #(
    parameter int DEPTH     = fqcbk_pkg::DEPTH_DEF,
    parameter int KEY_BITS  = fqcbk_pkg::KEY_BITS_DEF,
    parameter int FOOD_BITS = fqcbk_pkg::FOOD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [fqcbk_pkg::MODE_W-1:0]      i_mode,
    input  logic [fqcbk_pkg::KEY_W-1:0]       i_customer_key,
    input  logic [fqcbk_pkg::FOOD_W-1:0]      i_food_code,
    output logic                              o_valid,
    output logic [fqcbk_pkg::ID_W-1:0]        o_order_id,
    output logic [fqcbk_pkg::KEY_W-1:0]       o_entry_key,
    output logic [fqcbk_pkg::FOOD_W-1:0]      o_entry_food,
    output logic [fqcbk_pkg::COUNT_W-1:0]     o_queue_count,
    output logic [fqcbk_pkg::CODE_W-1:0]      o_result_code,
    output logic                              o_last
);
    import fqcbk_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int KW    = KEY_BITS;
    localparam int FW    = FOOD_BITS;
    localparam int KKEEP = (KW < KEY_W) ? KW : KEY_W;
    localparam int FKEEP = (FW < FOOD_W) ? FW : FOOD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_FRONT,
        S_SHIFT,
        S_SCAN,
        S_SFIN,
        S_FIND
    } t_state;

    t_state              r_state;
    logic [MODE_W-1:0]   r_mode;
    logic [KW-1:0]       r_key;
    logic [FW-1:0]       r_food;
    logic [CW-1:0]       r_occ;
    logic [CW-1:0]       r_cnt;
    logic [ID_W-1:0]     r_next_id;
    logic                r_hit;
    logic [ID_W-1:0]     r_h_id;
    logic [KW-1:0]       r_h_key;
    logic [FW-1:0]       r_h_food;

    logic                r_valid;
    logic [ID_W-1:0]     r_out_id;
    logic [KEY_W-1:0]    r_out_key;
    logic [FOOD_W-1:0]   r_out_food;
    logic [CODE_W-1:0]   r_out_code;
    logic                r_out_last;

    logic [ID_W-1:0]     mem_id   [DEPTH];
    logic [KW-1:0]       mem_key  [DEPTH];
    logic [FW-1:0]       mem_food [DEPTH];
    logic [ID_W-1:0]     r_rd_id;
    logic [KW-1:0]       r_rd_key;
    logic [FW-1:0]       r_rd_food;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [AW-1:0]       mem_raddr;
    logic [ID_W-1:0]     mem_wid;
    logic [KW-1:0]       mem_wkey;
    logic [FW-1:0]       mem_wfood;

    logic                full;
    logic                at_end;
    logic                match;

    assign full   = (r_occ == CW'(DEPTH));
    assign at_end = (r_cnt == r_occ - CW'(1));
    assign match  = (r_rd_key == r_key);

    always_comb begin
        mem_raddr = (r_state == S_DISPATCH) ? '0 : r_cnt[AW-1:0] + AW'(1);
        mem_we    = ((r_state == S_DISPATCH) && (r_mode == MODE_ENQ) && !full)
                    || (r_state == S_SHIFT);
        if (r_state == S_SHIFT) begin
            mem_waddr = r_cnt[AW-1:0] - AW'(1);
            mem_wid   = r_rd_id;
            mem_wkey  = r_rd_key;
            mem_wfood = r_rd_food;
        end else begin
            mem_waddr = r_occ[AW-1:0];
            mem_wid   = r_next_id;
            mem_wkey  = r_key;
            mem_wfood = r_food;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_id[mem_waddr]   <= mem_wid;
            mem_key[mem_waddr]  <= mem_wkey;
            mem_food[mem_waddr] <= mem_wfood;
        end
        r_rd_id   <= mem_id[mem_raddr];
        r_rd_key  <= mem_key[mem_raddr];
        r_rd_food <= mem_food[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_occ     <= '0;
            r_next_id <= ID_START;
            r_valid   <= 1'b0;
            r_hit     <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_mode  <= i_mode;
                        r_key   <= KW'(i_customer_key[KKEEP-1:0]);
                        r_food  <= FW'(i_food_code[FKEEP-1:0]);
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_cnt <= '0;
                    r_hit <= 1'b0;
                    case (r_mode)
                        MODE_ENQ: begin
                            r_valid    <= 1'b1;
                            r_out_last <= 1'b1;
                            r_state    <= S_IDLE;
                            if (full) begin
                                r_out_id   <= '0;
                                r_out_key  <= '0;
                                r_out_food <= '0;
                                r_out_code <= RES_FULL;
                            end else begin
                                r_out_id   <= r_next_id;
                                r_out_key  <= KEY_W'(r_key[KKEEP-1:0]);
                                r_out_food <= FOOD_W'(r_food[FKEEP-1:0]);
                                r_out_code <= RES_OK;
                                r_occ      <= r_occ + CW'(1);
                                r_next_id  <= r_next_id + ID_W'(1);
                            end
                        end
                        MODE_SERVE, MODE_PEEK, MODE_SEARCH, MODE_CANCEL: begin
                            if (r_occ == '0) begin
                                r_valid    <= 1'b1;
                                r_out_last <= 1'b1;
                                r_out_id   <= '0;
                                r_out_key  <= '0;
                                r_out_food <= '0;
                                r_out_code <= RES_MISS;
                                r_state    <= S_IDLE;
                            end else if (r_mode == MODE_SEARCH) begin
                                r_state <= S_SCAN;
                            end else if (r_mode == MODE_CANCEL) begin
                                r_state <= S_FIND;
                            end else begin
                                r_state <= S_FRONT;
                            end
                        end
                        default: begin
                            r_valid    <= 1'b1;
                            r_out_last <= 1'b1;
                            r_out_id   <= '0;
                            r_out_key  <= '0;
                            r_out_food <= '0;
                            r_out_code <= RES_OK;
                            r_state    <= S_IDLE;
                        end
                    endcase
                end
                S_FRONT: begin
                    r_h_id   <= r_rd_id;
                    r_h_key  <= r_rd_key;
                    r_h_food <= r_rd_food;
                    if ((r_mode == MODE_PEEK) || at_end) begin
                        r_valid    <= 1'b1;
                        r_out_last <= 1'b1;
                        r_out_id   <= r_rd_id;
                        r_out_key  <= KEY_W'(r_rd_key[KKEEP-1:0]);
                        r_out_food <= FOOD_W'(r_rd_food[FKEEP-1:0]);
                        r_out_code <= RES_OK;
                        r_state    <= S_IDLE;
                        if (r_mode != MODE_PEEK) begin
                            r_occ <= r_occ - CW'(1);
                        end
                    end else begin
                        r_cnt   <= r_cnt + CW'(1);
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (at_end) begin
                        r_valid    <= 1'b1;
                        r_out_last <= 1'b1;
                        r_out_id   <= r_h_id;
                        r_out_key  <= KEY_W'(r_h_key[KKEEP-1:0]);
                        r_out_food <= FOOD_W'(r_h_food[FKEEP-1:0]);
                        r_out_code <= RES_OK;
                        r_occ      <= r_occ - CW'(1);
                        r_state    <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_SCAN: begin
                    if (match) begin
                        if (r_hit) begin
                            r_valid    <= 1'b1;
                            r_out_last <= 1'b0;
                            r_out_id   <= r_h_id;
                            r_out_key  <= KEY_W'(r_h_key[KKEEP-1:0]);
                            r_out_food <= FOOD_W'(r_h_food[FKEEP-1:0]);
                            r_out_code <= RES_OK;
                        end
                        r_h_id   <= r_rd_id;
                        r_h_key  <= r_rd_key;
                        r_h_food <= r_rd_food;
                        r_hit    <= 1'b1;
                    end
                    if (at_end) begin
                        r_state <= S_SFIN;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_SFIN: begin
                    r_valid    <= 1'b1;
                    r_out_last <= 1'b1;
                    r_state    <= S_IDLE;
                    if (r_hit) begin
                        r_out_id   <= r_h_id;
                        r_out_key  <= KEY_W'(r_h_key[KKEEP-1:0]);
                        r_out_food <= FOOD_W'(r_h_food[FKEEP-1:0]);
                        r_out_code <= RES_OK;
                    end else begin
                        r_out_id   <= '0;
                        r_out_key  <= '0;
                        r_out_food <= '0;
                        r_out_code <= RES_MISS;
                    end
                end
                S_FIND: begin
                    if (match) begin
                        r_h_id   <= r_rd_id;
                        r_h_key  <= r_rd_key;
                        r_h_food <= r_rd_food;
                        if (at_end) begin
                            r_valid    <= 1'b1;
                            r_out_last <= 1'b1;
                            r_out_id   <= r_rd_id;
                            r_out_key  <= KEY_W'(r_rd_key[KKEEP-1:0]);
                            r_out_food <= FOOD_W'(r_rd_food[FKEEP-1:0]);
                            r_out_code <= RES_OK;
                            r_occ      <= r_occ - CW'(1);
                            r_state    <= S_IDLE;
                        end else begin
                            r_cnt   <= r_cnt + CW'(1);
                            r_state <= S_SHIFT;
                        end
                    end else if (at_end) begin
                        r_valid    <= 1'b1;
                        r_out_last <= 1'b1;
                        r_out_id   <= '0;
                        r_out_key  <= '0;
                        r_out_food <= '0;
                        r_out_code <= RES_MISS;
                        r_state    <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_order_id    = r_out_id;
    assign o_entry_key   = r_out_key;
    assign o_entry_food  = r_out_food;
    assign o_queue_count = COUNT_W'(r_occ);
    assign o_result_code = r_out_code;
    assign o_last        = r_out_last;

endmodule

`default_nettype wire

FILE: hdl/fqcbk_checker.sv
// port-level checks for the order queue, bound to the top level
`default_nettype none

`include "fifo_queue_with_cancel_by_key_core_assert.svh"

module fqcbk_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              o_valid,
    input  logic [fqcbk_pkg::ID_W-1:0]        o_order_id,
    input  logic [fqcbk_pkg::KEY_W-1:0]       o_entry_key,
    input  logic [fqcbk_pkg::FOOD_W-1:0]      o_entry_food,
    input  logic [fqcbk_pkg::CODE_W-1:0]      o_result_code,
    input  logic                              o_last
);
    import fqcbk_pkg::*;

    logic empty_entry;

    assign empty_entry = (o_order_id == '0) && (o_entry_key == '0) && (o_entry_food == '0);

    // a taken command keeps the block busy
    `FQCBK_CHECK_NEXT(a_accept_busy, start && !busy, busy)

    // no beat appears out of an idle cycle with no command
    `FQCBK_CHECK_NEXT(a_idle_quiet, !busy && !start, !o_valid)

    // the final beat frees the block, an earlier one does not
    `FQCBK_CHECK_NOW(a_last_frees, o_valid && o_last, !busy)
    `FQCBK_CHECK_NOW(a_more_busy, o_valid && !o_last, busy)

    // error beats are single and carry no entry
    `FQCBK_CHECK_NOW(a_err_clean, o_valid && (o_result_code != RES_OK), o_last && empty_entry)

endmodule

bind fifo_queue_with_cancel_by_key_core fqcbk_checker u_fqcbk_checker (.*);

`default_nettype wire
